@@ rtl/core/kmpt_pkg.sv @@
// Shared types, constants and the entry ordering function for the keyed minimum priority table.
package kmpt_pkg;

  localparam int PRIO_W  = 32;
  localparam int CHUNK_W = 6;
  localparam int NODE_W  = 8;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_ERASE  = 1'b1;

  typedef struct packed {
    logic                     valid;
    logic signed [PRIO_W-1:0] prio;
    logic [CHUNK_W-1:0]       lo;
    logic [CHUNK_W-1:0]       hi;
    logic [NODE_W-1:0]        node;
  } entry_t;

  typedef struct packed {
    logic del_en;
    logic ins_en;
  } cell_ctrl_t;

  // True if entry a orders strictly before entry b.
  function automatic logic entry_less(entry_t a, entry_t b);
    logic [PRIO_W+2*CHUNK_W+NODE_W-1:0] ka;
    logic [PRIO_W+2*CHUNK_W+NODE_W-1:0] kb;
    ka = {~a.prio[PRIO_W-1], a.prio[PRIO_W-2:0], a.lo, a.hi, a.node};
    kb = {~b.prio[PRIO_W-1], b.prio[PRIO_W-2:0], b.lo, b.hi, b.node};
    return ka < kb;
  endfunction

  function automatic logic key_equal(entry_t a, entry_t b);
    return (a.lo == b.lo) && (a.hi == b.hi) && (a.node == b.node);
  endfunction

endpackage

@@ rtl/core/kmpt_in_if.sv @@
// Request channel interface of the keyed minimum priority table.
interface kmpt_in_if
  import kmpt_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic                     kind;
  logic signed [PRIO_W-1:0] priority_req;
  logic [CHUNK_W-1:0]       chunk_a;
  logic [CHUNK_W-1:0]       chunk_b;
  logic [NODE_W-1:0]        node_id;

  modport source (output valid, kind, priority_req, chunk_a, chunk_b, node_id, input ready);
  modport sink (input valid, kind, priority_req, chunk_a, chunk_b, node_id, output ready);
endinterface

@@ rtl/core/kmpt_out_if.sv @@
// Result channel interface of the keyed minimum priority table.
interface kmpt_out_if
  import kmpt_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic                     top_valid;
  logic signed [PRIO_W-1:0] top_priority;
  logic [CHUNK_W-1:0]       top_low_chunk;
  logic [CHUNK_W-1:0]       top_high_chunk;
  logic [NODE_W-1:0]        top_node;
  logic                     dropped;

  modport source (output valid, top_valid, top_priority, top_low_chunk, top_high_chunk,
                  top_node, dropped, input ready);
  modport sink (input valid, top_valid, top_priority, top_low_chunk, top_high_chunk,
                top_node, dropped, output ready);
endinterface

@@ rtl/core/kmpt_cell.sv @@
// One slot of the sorted entry chain with its key match and order compare.
module kmpt_cell
  import kmpt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cell_ctrl_t ctrl_i,
  input  entry_t     new_i,
  input  entry_t     left_i,
  input  logic       left_less_i,
  input  entry_t     right_i,
  input  logic       after_i,
  output entry_t     entry_o,
  output logic       match_o,
  output logic       less_o
);

  entry_t entry_r;
  entry_t entry_nxt;

  assign match_o = entry_r.valid && key_equal(entry_r, new_i);
  assign less_o  = !entry_r.valid || entry_less(new_i, entry_r);
  assign entry_o = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (ctrl_i.del_en && after_i) begin
      entry_nxt = right_i;
    end else if (ctrl_i.ins_en && less_o) begin
      entry_nxt = left_less_i ? left_i : new_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r <= '0;
    end else begin
      entry_r <= entry_nxt;
    end
  end

endmodule

@@ rtl/core/kmpt_prefix_or.sv @@
// Log-depth prefix OR that marks every slot at or after a matching slot.
module kmpt_prefix_or #(
  parameter int N = 256
) (
  input  logic [N-1:0] bits_i,
  output logic [N-1:0] prefix_o
);

  localparam int LEVELS = (N > 1) ? $clog2(N) : 1;

  logic [LEVELS:0][N-1:0] lvl;

  assign lvl[0] = bits_i;

  for (genvar k = 0; k < LEVELS; k++) begin : g_lvl
    for (genvar i = 0; i < N; i++) begin : g_bit
      if (i >= (1 << k)) begin : g_or
        assign lvl[k+1][i] = lvl[k][i] | lvl[k][i-(1<<k)];
      end else begin : g_pass
        assign lvl[k+1][i] = lvl[k][i];
      end
    end
  end

  assign prefix_o = lvl[LEVELS];

endmodule

@@ rtl/core/keyed_min_priority_table_top.sv @@
// Top level of the keyed minimum priority table built as a sorted chain of cells.
//
// Requests arrive on in_ch: insert or replace (kind 0) or erase (kind 1) of an entry
// keyed by an unordered chunk pair and a node. Every request yields exactly one
// result on out_ch: the current minimum entry, with top_valid low and zero fields
// when the table is empty, and dropped high when an insert found the table full.
// The cells stay sorted by priority, low chunk, high chunk and node, so the
// minimum always sits in the first cell.
// A request is handled in steps: the transfer is taken and the key normalized, a
// matching entry is removed (the chain closes the gap by shifting left), and the
// entry is inserted (the chain opens a gap by shifting right). The result is loaded
// into the output register in the result state that follows, once the output is
// free; the next request may already be taken there, but not before.
// While a result waits for the receiver, the block holds it and does not load
// a newer one; in_ch stays ready only until that new result is due.
// Reset empties every cell and the output register.
module keyed_min_priority_table_top
  import kmpt_pkg::*;
#(
  parameter int ENTRIES    = 256,
  parameter int MAX_CHUNKS = 64,
  parameter int MAX_NODES  = 256
) (
  input logic             clk,
  input logic             rst_n,
  kmpt_in_if.sink         in_ch,
  kmpt_out_if.source      out_ch
);

  localparam int CNT_W = $clog2(ENTRIES + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DEL,
    S_INS,
    S_RES
  } state_t;

  state_t           state_r;
  logic             kind_r;
  logic             ok_r;
  entry_t           new_r;
  logic [CNT_W-1:0] count_r;
  entry_t           res_r;
  logic             dropped_r;
  logic             out_valid_r;
  logic             drop_pend_r;

  entry_t           cell_e [ENTRIES];
  logic [ENTRIES-1:0] match_w;
  logic [ENTRIES-1:0] less_w;
  logic [ENTRIES-1:0] after_w;
  cell_ctrl_t       ctrl;

  logic             in_xfer;
  logic             out_free;
  logic             full;
  logic [CHUNK_W-1:0] lo_w;
  logic [CHUNK_W-1:0] hi_w;
  logic             ok_w;

  assign full     = (count_r == CNT_W'(ENTRIES));
  assign out_free = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE) || ((state_r == S_RES) && out_free);
  assign in_xfer  = in_ch.valid && in_ch.ready;

  assign lo_w = (in_ch.chunk_a < in_ch.chunk_b) ? in_ch.chunk_a : in_ch.chunk_b;
  assign hi_w = (in_ch.chunk_a < in_ch.chunk_b) ? in_ch.chunk_b : in_ch.chunk_a;
  assign ok_w = (in_ch.chunk_a != in_ch.chunk_b)
             && (32'(in_ch.chunk_a) < 32'(MAX_CHUNKS))
             && (32'(in_ch.chunk_b) < 32'(MAX_CHUNKS))
             && (32'(in_ch.node_id) < 32'(MAX_NODES));

  assign ctrl.del_en = (state_r == S_DEL) && ok_r;
  assign ctrl.ins_en = (state_r == S_INS) && ok_r && (kind_r == KIND_INSERT) && !full;

  kmpt_prefix_or #(.N(ENTRIES)) u_prefix (
    .bits_i   (match_w),
    .prefix_o (after_w)
  );

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    entry_t left_e;
    entry_t right_e;
    logic   left_less;
    if (i == 0) begin : g_first
      assign left_e    = '0;
      assign left_less = 1'b0;
    end else begin : g_mid_l
      assign left_e    = cell_e[i-1];
      assign left_less = less_w[i-1];
    end
    if (i == ENTRIES - 1) begin : g_last
      assign right_e = '0;
    end else begin : g_mid_r
      assign right_e = cell_e[i+1];
    end
    kmpt_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl_i      (ctrl),
      .new_i       (new_r),
      .left_i      (left_e),
      .left_less_i (left_less),
      .right_i     (right_e),
      .after_i     (after_w[i]),
      .entry_o     (cell_e[i]),
      .match_o     (match_w[i]),
      .less_o      (less_w[i])
    );
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      kind_r     <= in_ch.kind;
      new_r      <= '{valid: 1'b1, prio: in_ch.priority_req, lo: lo_w, hi: hi_w,
                      node: in_ch.node_id};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ok_r        <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      drop_pend_r <= 1'b0;
      dropped_r   <= 1'b0;
      res_r       <= '0;
    end else begin
      if (out_valid_r && out_ch.ready && (state_r != S_RES)) begin
        out_valid_r <= 1'b0;
      end
      if (in_xfer) begin
        ok_r <= ok_w;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            state_r <= S_DEL;
          end
        end
        S_DEL: begin
          if (ok_r && after_w[ENTRIES-1]) begin
            count_r <= count_r - CNT_W'(1);
          end
          state_r <= S_INS;
        end
        S_INS: begin
          if (ctrl.ins_en) begin
            count_r <= count_r + CNT_W'(1);
          end
          drop_pend_r <= ok_r && (kind_r == KIND_INSERT) && full;
          state_r     <= S_RES;
        end
        S_RES: begin
          if (out_free) begin
            res_r       <= cell_e[0].valid ? cell_e[0] : '0;
            dropped_r   <= drop_pend_r;
            out_valid_r <= 1'b1;
            state_r     <= in_xfer ? S_DEL : S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.top_valid      = res_r.valid;
  assign out_ch.top_priority   = res_r.prio;
  assign out_ch.top_low_chunk  = res_r.lo;
  assign out_ch.top_high_chunk = res_r.hi;
  assign out_ch.top_node       = res_r.node;
  assign out_ch.dropped        = dropped_r;

endmodule

@@ rtl/core/kmpt_checker.sv @@
// Port-level checks of the keyed minimum priority table and their bind.
module kmpt_checker
  import kmpt_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic                     top_valid,
  input logic signed [PRIO_W-1:0] top_priority,
  input logic [CHUNK_W-1:0]       top_low_chunk,
  input logic [CHUNK_W-1:0]       top_high_chunk,
  input logic [NODE_W-1:0]        top_node,
  input logic                     dropped
);

  // A result that waits for the receiver stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(top_priority) && $stable(dropped))
    else $error("result changed while stalled");

  // An empty table reports all zero fields.
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !top_valid |-> (top_priority == '0) && (top_low_chunk == '0)
                                && (top_high_chunk == '0) && (top_node == '0))
    else $error("empty table reported nonzero fields");

  // A lost insert means the table is full, so it cannot look empty.
  a_drop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && dropped |-> top_valid)
    else $error("drop reported with an empty table");

  // The stored key is always normalized.
  a_key_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && top_valid |-> top_low_chunk < top_high_chunk)
    else $error("minimum entry key not normalized");

  // Each request passes through the remove and insert states, so ready drops right after its transfer.
  a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken in consecutive cycles");

endmodule

bind keyed_min_priority_table_top kmpt_checker u_kmpt_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .top_valid      (out_ch.top_valid),
  .top_priority   (out_ch.top_priority),
  .top_low_chunk  (out_ch.top_low_chunk),
  .top_high_chunk (out_ch.top_high_chunk),
  .top_node       (out_ch.top_node),
  .dropped        (out_ch.dropped)
);

@@ tb/tb_top.sv @@
// Self-checking testbench for the keyed minimum priority table against a local table model.
module tb_top;
  import kmpt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH = 256;
  localparam int POOL_SIZE   = 320;

  typedef struct {
    logic                     kind;
    logic signed [PRIO_W-1:0] prio;
    logic [CHUNK_W-1:0]       chunk_a;
    logic [CHUNK_W-1:0]       chunk_b;
    logic [NODE_W-1:0]        node;
    int                       gap_after;
    bit                       wait_empty;
  } table_req_t;

  typedef struct {
    logic                     top_valid;
    logic signed [PRIO_W-1:0] prio;
    logic [CHUNK_W-1:0]       lo;
    logic [CHUNK_W-1:0]       hi;
    logic [NODE_W-1:0]        node;
    logic                     dropped;
  } table_top_t;

  logic clk;
  logic rst_n;

  kmpt_in_if  in_ch ();
  kmpt_out_if out_ch ();

  keyed_min_priority_table_top u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  table_req_t request_q[$];
  table_top_t expected_top_q[$];

  bit                       model_used [TABLE_DEPTH];
  logic signed [PRIO_W-1:0] model_prio [TABLE_DEPTH];
  logic [CHUNK_W-1:0]       model_lo [TABLE_DEPTH];
  logic [CHUNK_W-1:0]       model_hi [TABLE_DEPTH];
  logic [NODE_W-1:0]        model_node [TABLE_DEPTH];
  int                       model_count = 0;
  int                       peak_count = 0;

  logic [CHUNK_W-1:0] pool_a [POOL_SIZE];
  logic [CHUNK_W-1:0] pool_b [POOL_SIZE];
  logic [NODE_W-1:0]  pool_node [POOL_SIZE];

  table_req_t cur_req;
  bit         busy = 0;
  int         idle_left = 0;
  int         sent_count = 0;
  bit         no_gaps = 0;

  bit hold_out = 0;
  int stall_left = 0;
  int mode_left = 0;
  bit calm = 0;
  int checked_count = 0;
  int empty_seen = 0;
  int drops_seen = 0;
  int err_count = 0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic logic signed [PRIO_W-1:0] pick_prio();
    int r;
    r = $urandom_range(0, 7);
    case (r)
      0: begin
        case ($urandom_range(0, 4))
          0: return 32'sh8000_0000;
          1: return 32'sh7fff_ffff;
          2: return 32'sh0000_0000;
          3: return -32'sd1;
          default: return 32'sh0001_0000;
        endcase
      end
      1, 2: return $signed($urandom_range(0, 8)) - 32'sd4;
      default: return $signed($urandom);
    endcase
  endfunction

  task automatic add_req(input logic kind, input logic signed [PRIO_W-1:0] prio,
                         input logic [CHUNK_W-1:0] a, input logic [CHUNK_W-1:0] b,
                         input logic [NODE_W-1:0] node, input bit wait_empty);
    table_req_t r;
    r.kind       = kind;
    r.prio       = prio;
    r.chunk_a    = a;
    r.chunk_b    = b;
    r.node       = node;
    r.gap_after  = no_gaps ? 0 : pick_gap();
    r.wait_empty = wait_empty;
    request_q.push_back(r);
  endtask

  task automatic add_pool_req(input logic kind, input int k, input bit wait_empty);
    logic [CHUNK_W-1:0] a;
    logic [CHUNK_W-1:0] b;
    a = pool_a[k];
    b = pool_b[k];
    if ($urandom_range(0, 1) == 1) begin
      a = pool_b[k];
      b = pool_a[k];
    end
    add_req(kind, kind == KIND_INSERT ? pick_prio() : $signed($urandom), a, b,
            pool_node[k], wait_empty);
  endtask

  task automatic update_table_and_min(input table_req_t r);
    logic [CHUNK_W-1:0] lo;
    logic [CHUNK_W-1:0] hi;
    int                 hit;
    int                 slot;
    table_top_t         top;
    top = '{default: '0};
    lo = (r.chunk_a < r.chunk_b) ? r.chunk_a : r.chunk_b;
    hi = (r.chunk_a < r.chunk_b) ? r.chunk_b : r.chunk_a;
    if (r.chunk_a != r.chunk_b) begin
      hit = -1;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        if (model_used[i] && model_lo[i] == lo && model_hi[i] == hi && model_node[i] == r.node)
          hit = i;
      end
      if (r.kind == KIND_INSERT) begin
        if (hit >= 0) begin
          model_prio[hit] = r.prio;
        end else if (model_count >= TABLE_DEPTH) begin
          top.dropped = 1'b1;
        end else begin
          slot = -1;
          for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (!model_used[i] && slot < 0) slot = i;
          end
          model_used[slot] = 1'b1;
          model_prio[slot] = r.prio;
          model_lo[slot]   = lo;
          model_hi[slot]   = hi;
          model_node[slot] = r.node;
          model_count++;
          if (model_count > peak_count) peak_count = model_count;
        end
      end else if (hit >= 0) begin
        model_used[hit] = 1'b0;
        model_count--;
      end
    end
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (model_used[i] && (!top.top_valid || model_prio[i] < top.prio ||
          (model_prio[i] == top.prio &&
           {model_lo[i], model_hi[i], model_node[i]} < {top.lo, top.hi, top.node}))) begin
        top.top_valid = 1'b1;
        top.prio      = model_prio[i];
        top.lo        = model_lo[i];
        top.hi        = model_hi[i];
        top.node      = model_node[i];
      end
    end
    expected_top_q.push_back(top);
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_val,
                             input logic [31:0] got_val);
    if (exp_val !== got_val) begin
      $display("%0t: %s expected %h actual %h", $realtime, name, exp_val, got_val);
      err_count++;
    end
  endtask

  always #2 clk = ~clk;

  // Driver: one request per transfer, with the gap that follows it.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      busy = 0;
      idle_left = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        update_table_and_min(cur_req);
        sent_count++;
        busy = 0;
        idle_left = cur_req.gap_after;
      end
      if (!busy) begin
        if (idle_left > 0) begin
          idle_left--;
          in_ch.valid <= 1'b0;
        end else if (request_q.size() > 0 &&
                     (!request_q[0].wait_empty || expected_top_q.size() == 0)) begin
          cur_req = request_q.pop_front();
          busy = 1;
          in_ch.kind         <= cur_req.kind;
          in_ch.priority_req <= cur_req.prio;
          in_ch.chunk_a      <= cur_req.chunk_a;
          in_ch.chunk_b      <= cur_req.chunk_b;
          in_ch.node_id      <= cur_req.node;
          in_ch.valid        <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks every result transfer and stalls the result channel at random.
  always @(posedge clk) begin
    table_top_t exp_top;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        checked_count++;
        if (!out_ch.top_valid) empty_seen++;
        if (out_ch.dropped) drops_seen++;
        if (expected_top_q.size() == 0) begin
          $display("%0t: unexpected result expected none actual valid=%b prio=%h", $realtime,
                   out_ch.top_valid, out_ch.top_priority);
          err_count++;
        end else begin
          exp_top = expected_top_q.pop_front();
          check_field("top_valid", 32'(exp_top.top_valid), 32'(out_ch.top_valid));
          check_field("top_priority", exp_top.prio, out_ch.top_priority);
          check_field("top_low_chunk", 32'(exp_top.lo), 32'(out_ch.top_low_chunk));
          check_field("top_high_chunk", 32'(exp_top.hi), 32'(out_ch.top_high_chunk));
          check_field("top_node", 32'(exp_top.node), 32'(out_ch.top_node));
          check_field("dropped", 32'(exp_top.dropped), 32'(out_ch.dropped));
        end
      end
      if (mode_left == 0) begin
        calm = ($urandom_range(0, 3) == 0);
        mode_left = $urandom_range(200, 800);
      end else begin
        mode_left--;
      end
      if (hold_out) begin
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (!calm) stall_left = pick_gap();
      end
    end
  end

  // A long hold-off on the result channel while requests keep coming.
  initial begin
    wait (sent_count >= 400);
    @(posedge clk);
    hold_out <= 1'b1;
    repeat (300) @(posedge clk);
    hold_out <= 1'b0;
  end

  initial begin
    #2_000_000;
    $display("keyed_min_priority_table_top: mismatch");
    $finish;
  end

  initial begin
    int order [POOL_SIZE];
    int j;
    int tmp;
    int k;
    logic kind;
    logic [CHUNK_W-1:0] a;
    logic [CHUNK_W-1:0] b;

    clk = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_INSERT;
    in_ch.priority_req = '0;
    in_ch.chunk_a = '0;
    in_ch.chunk_b = '0;
    in_ch.node_id = '0;
    out_ch.ready = 1'b0;

    add_req(KIND_ERASE, 32'sh1234_5678, 6'd0, 6'd1, 8'd0, 0);
    add_req(KIND_INSERT, 32'sh0000_0000, 6'd5, 6'd9, 8'd7, 0);
    add_req(KIND_INSERT, 32'sh7fff_ffff, 6'd63, 6'd0, 8'd255, 0);
    add_req(KIND_INSERT, 32'sh8000_0000, 6'd0, 6'd63, 8'd0, 0);
    add_req(KIND_INSERT, 32'sh8000_0000, 6'd12, 6'd12, 8'd3, 0);
    add_req(KIND_ERASE, 32'sh0, 6'd63, 6'd63, 8'd255, 0);
    add_req(KIND_INSERT, -32'sd1, 6'd9, 6'd5, 8'd7, 0);
    add_req(KIND_INSERT, 32'sh8000_0000, 6'd0, 6'd62, 8'd0, 0);
    add_req(KIND_INSERT, 32'sh8000_0000, 6'd0, 6'd62, 8'd255, 0);
    add_req(KIND_ERASE, 32'shffff_ffff, 6'd62, 6'd0, 8'd0, 0);
    add_req(KIND_ERASE, 32'sh0, 6'd1, 6'd2, 8'd3, 0);
    add_req(KIND_INSERT, 32'sh8000_0000, 6'd1, 6'd2, 8'd0, 0);
    add_req(KIND_ERASE, 32'sh0, 6'd0, 6'd62, 8'd255, 0);
    add_req(KIND_INSERT, 32'sh7fff_ffff, 6'd63, 6'd0, 8'd0, 0);
    add_req(KIND_ERASE, 32'sh0, 6'd0, 6'd63, 8'd0, 0);
    add_req(KIND_INSERT, 32'shaaaa_aaaa, 6'd42, 6'd21, 8'haa, 0);
    add_req(KIND_INSERT, 32'sh5555_5555, 6'd21, 6'd42, 8'h55, 0);
    add_req(KIND_ERASE, 32'sh5555_5555, 6'd42, 6'd21, 8'haa, 0);
    add_req(KIND_ERASE, 32'shaaaa_aaaa, 6'd21, 6'd42, 8'h55, 0);
    add_req(KIND_ERASE, 32'sh0, 6'd5, 6'd9, 8'd7, 0);
    add_req(KIND_ERASE, 32'sh0, 6'd63, 6'd0, 8'd255, 0);
    add_req(KIND_ERASE, 32'sh0, 6'd2, 6'd1, 8'd0, 0);
    add_req(KIND_ERASE, 32'sh0, 6'd2, 6'd1, 8'd0, 0);

    for (int i = 0; i < POOL_SIZE; i++) begin
      pool_a[i] = CHUNK_W'($urandom_range(0, 62));
      pool_b[i] = CHUNK_W'($urandom_range(32'(pool_a[i]) + 32'd1, 63));
      pool_node[i] = i[NODE_W-1:0] ^ NODE_W'($urandom_range(0, 1) * 8'h80);
      order[i] = i;
    end

    // Fill past capacity so that the last inserts are lost.
    for (int i = 0; i < 300; i++) add_pool_req(KIND_INSERT, i, i == 0);

    for (int i = 0; i < 450; i++) begin
      if ($urandom_range(0, 19) == 0) begin
        a = CHUNK_W'($urandom_range(0, 63));
        add_req(($urandom_range(0, 1) == 1) ? KIND_ERASE : KIND_INSERT, pick_prio(), a, a,
                NODE_W'($urandom), 0);
      end else begin
        add_pool_req(($urandom_range(0, 9) < 6) ? KIND_INSERT : KIND_ERASE,
                     $urandom_range(0, POOL_SIZE - 1), 0);
      end
    end

    for (int i = POOL_SIZE - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    no_gaps = 1;
    for (int i = 0; i < POOL_SIZE; i++) add_pool_req(KIND_ERASE, order[i], i == 0);
    no_gaps = 0;

    for (int i = 0; i < 300; i++) begin
      kind = ($urandom_range(0, 99) < 65) ? KIND_INSERT : KIND_ERASE;
      k = $urandom_range(0, 2);
      if (k == 0) begin
        a = CHUNK_W'($urandom_range(0, 63));
        add_req(kind, pick_prio(), a, a, NODE_W'($urandom), i == 0);
      end else if (k == 1) begin
        a = CHUNK_W'($urandom_range(0, 7));
        b = CHUNK_W'($urandom_range(0, 7));
        add_req(kind, pick_prio(), a, b, NODE_W'($urandom_range(0, 3)), i == 0);
      end else begin
        add_req(kind, pick_prio(), CHUNK_W'($urandom), CHUNK_W'($urandom),
                NODE_W'($urandom), i == 0);
      end
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    wait (request_q.size() == 0 && !busy && expected_top_q.size() == 0);
    repeat (20) @(posedge clk);

    $display("Checked %0d results for %0d requests; peak occupancy %0d of %0d entries.",
             checked_count, sent_count, peak_count, TABLE_DEPTH);
    $display("Results with an empty table: %0d; inserts lost to a full table: %0d.",
             empty_seen, drops_seen);
    if (err_count == 0 && expected_top_q.size() == 0) begin
      $display("keyed_min_priority_table_top: match");
    end else begin
      $display("keyed_min_priority_table_top: mismatch");
    end
    $finish;
  end

endmodule
